// File: rtl/slfr_pkg.sv
package slfr_pkg;

  localparam int ByteW   = 8;
  localparam int LenW    = 16;
  localparam int KindW   = 2;
  localparam int CfgIdxW = 2;
  localparam int CfgDatW = 16;
  localparam int InDataW = 8;
  localparam int OutDataW = 40;

  // Fixed number of timestamp bytes that follow an echo request
  localparam logic [LenW-1:0] ECHO_BYTES = 16'd8;

  // Result kinds
  typedef enum logic [KindW-1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ECHO    = 2'd2
  } kind_t;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_ECHO_DEVICE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_ECHO_PARAM  = 2'd2;

  typedef struct packed {
    logic [LenW-1:0]  sync_word;
    logic [ByteW-1:0] echo_device_code;
    logic [ByteW-1:0] echo_param_code;
  } cfg_t;

endpackage

// File: rtl/sync_length_frame_receiver.sv
// Sync-word, length-prefixed frame receiver.
// Path: a byte is accepted into the input register, then its result is loaded
// into the result register. Throughput: one byte per cycle unless the output
// stalls; the frame state update is a single pass.
// Reset: synchronous, active high; clears registers, frame state and both stages,
// and restarts the sync hunt.
module sync_length_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [slfr_pkg::CfgDatW-1:0]   cfg_data,
  // Received bytes
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slfr_pkg::InDataW-1:0]   s_tdata,   // [7:0] rx_byte
  // Frame results
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slfr_pkg::OutDataW-1:0]  m_tdata,   // [7:0] device, [15:8] param,
                                                    // [31:16] length, [39:32] data_byte
  output logic                           m_tlast,
  output logic [slfr_pkg::KindW-1:0]     m_tuser    // [1:0] kind
);
  import slfr_pkg::*;

  cfg_t cfg;

  slfr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slfr_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/slfr_cfg.sv
module slfr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [slfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [slfr_pkg::CfgDatW-1:0]  cfg_data,
  output slfr_pkg::cfg_t                cfg
);
  import slfr_pkg::*;

  cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  // Decode the register index and write on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_WORD:   regs.sync_word        <= cfg_data;
        REG_ECHO_DEVICE: regs.echo_device_code <= cfg_data[ByteW-1:0];
        REG_ECHO_PARAM:  regs.echo_param_code  <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/slfr_parse.sv
module slfr_parse (
  input  logic                           clk,
  input  logic                           rst,
  input  slfr_pkg::cfg_t                 cfg,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [slfr_pkg::ByteW-1:0]     s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [slfr_pkg::OutDataW-1:0]  m_tdata,
  output logic                           m_tlast,
  output logic [slfr_pkg::KindW-1:0]     m_tuser
);
  import slfr_pkg::*;

  typedef enum logic [7:0] {
    ST_SYNC_FIRST = 8'b0000_0001,
    ST_SYNC_SLIDE = 8'b0000_0010,
    ST_DEVICE     = 8'b0000_0100,
    ST_PARAM      = 8'b0000_1000,
    ST_LEN_HIGH   = 8'b0001_0000,
    ST_LEN_LOW    = 8'b0010_0000,
    ST_PAYLOAD    = 8'b0100_0000,
    ST_ECHO       = 8'b1000_0000
  } state_t;

  // Input register
  logic             in_valid;
  logic [ByteW-1:0] in_byte;

  // Frame state
  state_t           state, state_next;
  logic [ByteW-1:0] prev, prev_next;
  logic [ByteW-1:0] dev, dev_next;
  logic [ByteW-1:0] par, par_next;
  logic [LenW-1:0]  len, len_next;
  logic [LenW-1:0]  rem, rem_next;
  logic [LenW-1:0]  rem_dec;

  // Result of the byte in the input register
  logic             res_valid;
  kind_t            res_kind;
  logic [ByteW-1:0] res_data;
  logic             res_last;

  // Result register
  logic             out_valid;
  kind_t            out_kind;
  logic [ByteW-1:0] out_dev;
  logic [ByteW-1:0] out_par;
  logic [LenW-1:0]  out_len;
  logic [ByteW-1:0] out_data;
  logic             out_last;

  logic out_free;
  logic fire;

  assign out_free = !out_valid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Capture the incoming beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  assign rem_dec = (rem != '0) ? rem - 1'b1 : rem;

  // Advance the frame state for the held byte
  always_comb begin
    state_next = state;
    prev_next  = prev;
    dev_next   = dev;
    par_next   = par;
    len_next   = len;
    rem_next   = rem;
    res_valid  = 1'b0;
    res_kind   = KIND_HEADER;
    res_data   = '0;
    res_last   = 1'b0;
    unique case (state) inside
      ST_SYNC_FIRST: begin
        prev_next  = in_byte;
        state_next = ST_SYNC_SLIDE;
      end
      ST_SYNC_SLIDE: begin
        if ({prev, in_byte} == cfg.sync_word) begin
          state_next = ST_DEVICE;
        end
        prev_next = in_byte;
      end
      ST_DEVICE: begin
        dev_next   = in_byte;
        state_next = ST_PARAM;
      end
      ST_PARAM: begin
        par_next   = in_byte;
        state_next = ST_LEN_HIGH;
      end
      ST_LEN_HIGH: begin
        len_next   = {in_byte, {ByteW{1'b0}}};
        state_next = ST_LEN_LOW;
      end
      ST_LEN_LOW: begin
        len_next = {len[LenW-1:ByteW], in_byte};
        if (dev == cfg.echo_device_code && par == cfg.echo_param_code) begin
          rem_next   = ECHO_BYTES;
          state_next = ST_ECHO;
        end else if (len_next == '0) begin
          rem_next   = '0;
          state_next = ST_SYNC_FIRST;
          res_valid  = 1'b1;
          res_last   = 1'b1;
        end else begin
          rem_next   = len_next;
          state_next = ST_PAYLOAD;
          res_valid  = 1'b1;
        end
      end
      ST_PAYLOAD, ST_ECHO: begin
        rem_next  = rem_dec;
        res_valid = 1'b1;
        res_kind  = (state == ST_PAYLOAD) ? KIND_PAYLOAD : KIND_ECHO;
        res_data  = in_byte;
        res_last  = (rem_dec == '0);
        if (res_last) begin
          state_next = ST_SYNC_FIRST;
        end
      end
      default: begin
        state_next = ST_SYNC_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SYNC_FIRST;
      prev  <= '0;
      dev   <= '0;
      par   <= '0;
      len   <= '0;
      rem   <= '0;
    end else if (fire) begin
      state <= state_next;
      prev  <= prev_next;
      dev   <= dev_next;
      par   <= par_next;
      len   <= len_next;
      rem   <= rem_next;
    end
  end

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_kind <= res_kind;
      out_dev  <= dev_next;
      out_par  <= par_next;
      out_len  <= len_next;
      out_data <= res_data;
      out_last <= res_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_data, out_len, out_par, out_dev};
  assign m_tlast  = out_last;
  assign m_tuser  = out_kind;

  // A payload or echo run always has bytes left to count
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAYLOAD || state == ST_ECHO) |-> rem != '0)
    else $error("payload or echo phase with no bytes remaining");

  // An echo request loads exactly eight timestamp bytes
  a_echo_load: assert property (@(posedge clk) disable iff (rst)
    (fire && state == ST_LEN_LOW && dev == cfg.echo_device_code
      && par == cfg.echo_param_code)
    |=> (state == ST_ECHO && rem == ECHO_BYTES && !(out_valid && $changed(out_kind)
         && out_kind == KIND_HEADER)))
    else $error("echo request did not enter echo phase");

  // A header result ends the frame exactly when the length is zero
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_HEADER) |-> (out_last == (out_len == '0)))
    else $error("header last flag disagrees with length");

  // Only defined kinds are presented
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_HEADER || out_kind == KIND_PAYLOAD
                   || out_kind == KIND_ECHO))
    else $error("undefined result kind");

endmodule
